// ===== design/knapsack_01_selector_macros.svh =====
// assertion macros for the knapsack selector checker
// no dependencies; included by the checker file only
`ifndef KNAPSACK_01_SELECTOR_MACROS_SVH
`define KNAPSACK_01_SELECTOR_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define KS01_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define KS01_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/ks01_pkg.sv =====
// shared widths, constants and types of the knapsack selector
// no dependencies; imported by every module of the block
`default_nettype none

package ks01_pkg;

    localparam int PROFIT_W    = 21;
    localparam int IN_PROFIT_W = 16;
    localparam int COST_W      = 8;
    localparam int CAP_W       = 8;
    localparam int MASK_W      = 32;
    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 56;

    localparam logic [PROFIT_W-1:0] PROFIT_MAX = '1;

    // read and write enables of one memory
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } ks01_mem_ctl_t;

endpackage

`default_nettype wire

// ===== design/knapsack_01_selector.sv =====
// top level of the 0/1 knapsack selector: ports, capacity register, memories
// depends on ks01_pkg, ks01_profit_mem, ks01_take_mem and ks01_seq
`default_nettype none

// Each accepted item sweeps the whole best-profit row from budget MAX_CAPACITY
// down to 1, one budget per cycle through the row memory's read and write
// ports; an item dropped because MAX_ITEMS are already held is not swept.
// After the item flagged by s_tlast the trace back reads the best profit at
// the capacity budget, then held items' take bits and costs, and loads the
// result register, waiting if an earlier result is still held on m_tready,
// which does not stop the next problem's items. There is no clearing pass:
// the first item of a problem treats the row as empty and rewrites every
// entry above budget zero. The user must change the capacity register
// (cfg_valid/cfg_data) only while no problem is in flight; nothing enforces it.
module knapsack_01_selector #(
    parameter int MAX_ITEMS    = 32,
    parameter int MAX_CAPACITY = 255
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    // capacity register write
    input  wire                              cfg_valid,
    output logic                             cfg_ready,
    input  wire  [ks01_pkg::CAP_W-1:0]       cfg_data,
    // items; tdata: item_profit[15:0], item_cost[23:16]; tlast: last_item
    input  wire                              s_tvalid,
    output logic                             s_tready,
    input  wire  [ks01_pkg::S_TDATA_W-1:0]   s_tdata,
    input  wire                              s_tlast,
    // results; tdata: best_profit[20:0], chosen_mask[52:21], zero pad
    // tuser: too_many_items[0]
    output logic                             m_tvalid,
    input  wire                              m_tready,
    output logic [ks01_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                             m_tuser
);
    import ks01_pkg::*;

    localparam int DEPTH = MAX_CAPACITY + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int CNTW  = $clog2(MAX_ITEMS + 1);
    localparam int IDXW  = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;

    logic [CAP_W-1:0]    capacity_reg;

    ks01_mem_ctl_t        pm_ctl;
    logic [AW-1:0]        pm_rd_addr_a;
    logic [AW-1:0]        pm_rd_addr_b;
    logic [AW-1:0]        pm_wr_addr;
    logic [PROFIT_W-1:0]  pm_wr_data;
    logic [PROFIT_W-1:0]  pm_rd_data_a;
    logic [PROFIT_W-1:0]  pm_rd_data_b;
    ks01_mem_ctl_t        tk_ctl;
    logic [AW-1:0]        tk_rd_addr;
    logic [AW-1:0]        tk_wr_addr;
    logic [MAX_ITEMS-1:0] tk_wr_data;
    logic [MAX_ITEMS-1:0] tk_rd_data;
    ks01_mem_ctl_t        cs_ctl;
    logic [IDXW-1:0]      cs_rd_addr;
    logic [IDXW-1:0]      cs_wr_addr;
    logic [COST_W-1:0]    cs_wr_data;
    logic [COST_W-1:0]    cs_rd_data;
    logic [PROFIT_W-1:0]  out_best;
    logic [MASK_W-1:0]    out_mask;

    // capacity register, always ready for a transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= '0;
        end else if (cfg_valid) begin
            capacity_reg <= cfg_data;
        end
    end
    assign cfg_ready = 1'b1;

    ks01_profit_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_profit_mem (
        .aclk      (aclk),
        .ctl       (pm_ctl),
        .rd_addr_a (pm_rd_addr_a),
        .rd_addr_b (pm_rd_addr_b),
        .wr_addr   (pm_wr_addr),
        .wr_data   (pm_wr_data),
        .rd_data_a (pm_rd_data_a),
        .rd_data_b (pm_rd_data_b)
    );

    ks01_take_mem #(
        .DEPTH     (DEPTH),
        .AW        (AW),
        .MAX_ITEMS (MAX_ITEMS),
        .IDXW      (IDXW)
    ) u_take_mem (
        .aclk         (aclk),
        .take_ctl     (tk_ctl),
        .take_rd_addr (tk_rd_addr),
        .take_wr_addr (tk_wr_addr),
        .take_wr_data (tk_wr_data),
        .take_rd_data (tk_rd_data),
        .cost_ctl     (cs_ctl),
        .cost_rd_addr (cs_rd_addr),
        .cost_wr_addr (cs_wr_addr),
        .cost_wr_data (cs_wr_data),
        .cost_rd_data (cs_rd_data)
    );

    ks01_seq #(
        .MAX_ITEMS    (MAX_ITEMS),
        .MAX_CAPACITY (MAX_CAPACITY),
        .AW           (AW),
        .CNTW         (CNTW),
        .IDXW         (IDXW)
    ) u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_profit    (s_tdata[IN_PROFIT_W-1:0]),
        .in_cost      (s_tdata[IN_PROFIT_W +: COST_W]),
        .in_last      (s_tlast),
        .capacity     (capacity_reg),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_best     (out_best),
        .out_mask     (out_mask),
        .out_ovf      (m_tuser),
        .pm_ctl       (pm_ctl),
        .pm_rd_addr_a (pm_rd_addr_a),
        .pm_rd_addr_b (pm_rd_addr_b),
        .pm_wr_addr   (pm_wr_addr),
        .pm_wr_data   (pm_wr_data),
        .pm_rd_data_a (pm_rd_data_a),
        .pm_rd_data_b (pm_rd_data_b),
        .tk_ctl       (tk_ctl),
        .tk_rd_addr   (tk_rd_addr),
        .tk_wr_addr   (tk_wr_addr),
        .tk_wr_data   (tk_wr_data),
        .tk_rd_data   (tk_rd_data),
        .cs_ctl       (cs_ctl),
        .cs_rd_addr   (cs_rd_addr),
        .cs_wr_addr   (cs_wr_addr),
        .cs_wr_data   (cs_wr_data),
        .cs_rd_data   (cs_rd_data)
    );

    // result packing, profit in the low bits
    assign m_tdata = {(M_TDATA_W - PROFIT_W - MASK_W)'(0), out_mask, out_best};

endmodule

`default_nettype wire

// ===== design/ks01_profit_mem.sv =====
// best-profit row: one write port, two read ports, registered reads
// depends on ks01_pkg
`default_nettype none

module ks01_profit_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  wire                           aclk,
    input  ks01_pkg::ks01_mem_ctl_t       ctl,
    input  wire  [AW-1:0]                 rd_addr_a,
    input  wire  [AW-1:0]                 rd_addr_b,
    input  wire  [AW-1:0]                 wr_addr,
    input  wire  [ks01_pkg::PROFIT_W-1:0] wr_data,
    output logic [ks01_pkg::PROFIT_W-1:0] rd_data_a,
    output logic [ks01_pkg::PROFIT_W-1:0] rd_data_b
);
    import ks01_pkg::*;

    logic [PROFIT_W-1:0] mem [DEPTH];
    logic [PROFIT_W-1:0] rd_a_reg;
    logic [PROFIT_W-1:0] rd_b_reg;
    logic                zero_a_reg;
    logic                zero_b_reg;

    // write and registered reads
    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en) begin
            rd_a_reg   <= mem[rd_addr_a];
            rd_b_reg   <= mem[rd_addr_b];
            zero_a_reg <= (rd_addr_a == '0);
            zero_b_reg <= (rd_addr_b == '0);
        end
    end

    // budget zero is never written and always reads as zero
    assign rd_data_a = zero_a_reg ? '0 : rd_a_reg;
    assign rd_data_b = zero_b_reg ? '0 : rd_b_reg;

endmodule

`default_nettype wire

// ===== design/ks01_take_mem.sv =====
// take-bit rows per budget and per-item cost store, registered reads
// depends on ks01_pkg
`default_nettype none

module ks01_take_mem #(
    parameter int DEPTH     = 256,
    parameter int AW        = 8,
    parameter int MAX_ITEMS = 32,
    parameter int IDXW      = 5
) (
    input  wire                         aclk,
    input  ks01_pkg::ks01_mem_ctl_t     take_ctl,
    input  wire  [AW-1:0]               take_rd_addr,
    input  wire  [AW-1:0]               take_wr_addr,
    input  wire  [MAX_ITEMS-1:0]        take_wr_data,
    output logic [MAX_ITEMS-1:0]        take_rd_data,
    input  ks01_pkg::ks01_mem_ctl_t     cost_ctl,
    input  wire  [IDXW-1:0]             cost_rd_addr,
    input  wire  [IDXW-1:0]             cost_wr_addr,
    input  wire  [ks01_pkg::COST_W-1:0] cost_wr_data,
    output logic [ks01_pkg::COST_W-1:0] cost_rd_data
);
    import ks01_pkg::*;

    logic [MAX_ITEMS-1:0] take_mem [DEPTH];
    logic [COST_W-1:0]    cost_mem [MAX_ITEMS];

    // take bits
    always_ff @(posedge aclk) begin
        if (take_ctl.wr_en) begin
            take_mem[take_wr_addr] <= take_wr_data;
        end
        if (take_ctl.rd_en) begin
            take_rd_data <= take_mem[take_rd_addr];
        end
    end

    // item costs, kept for the trace back
    always_ff @(posedge aclk) begin
        if (cost_ctl.wr_en) begin
            cost_mem[cost_wr_addr] <= cost_wr_data;
        end
        if (cost_ctl.rd_en) begin
            cost_rd_data <= cost_mem[cost_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== design/ks01_seq.sv =====
// sequencer: row update pipeline, trace back and result register
// depends on ks01_pkg; drives ks01_profit_mem and ks01_take_mem
`default_nettype none

module ks01_seq #(
    parameter int MAX_ITEMS    = 32,
    parameter int MAX_CAPACITY = 255,
    parameter int AW           = 8,
    parameter int CNTW         = 6,
    parameter int IDXW         = 5
) (
    input  wire                                aclk,
    input  wire                                aresetn,
    // item channel
    input  wire                                in_valid,
    output logic                               in_ready,
    input  wire  [ks01_pkg::IN_PROFIT_W-1:0]   in_profit,
    input  wire  [ks01_pkg::COST_W-1:0]        in_cost,
    input  wire                                in_last,
    input  wire  [ks01_pkg::CAP_W-1:0]         capacity,
    // result channel
    output logic                               out_valid,
    input  wire                                out_ready,
    output logic [ks01_pkg::PROFIT_W-1:0]      out_best,
    output logic [ks01_pkg::MASK_W-1:0]        out_mask,
    output logic                               out_ovf,
    // profit row
    output ks01_pkg::ks01_mem_ctl_t            pm_ctl,
    output logic [AW-1:0]                      pm_rd_addr_a,
    output logic [AW-1:0]                      pm_rd_addr_b,
    output logic [AW-1:0]                      pm_wr_addr,
    output logic [ks01_pkg::PROFIT_W-1:0]      pm_wr_data,
    input  wire  [ks01_pkg::PROFIT_W-1:0]      pm_rd_data_a,
    input  wire  [ks01_pkg::PROFIT_W-1:0]      pm_rd_data_b,
    // take bits and costs
    output ks01_pkg::ks01_mem_ctl_t            tk_ctl,
    output logic [AW-1:0]                      tk_rd_addr,
    output logic [AW-1:0]                      tk_wr_addr,
    output logic [MAX_ITEMS-1:0]               tk_wr_data,
    input  wire  [MAX_ITEMS-1:0]               tk_rd_data,
    output ks01_pkg::ks01_mem_ctl_t            cs_ctl,
    output logic [IDXW-1:0]                    cs_rd_addr,
    output logic [IDXW-1:0]                    cs_wr_addr,
    output logic [ks01_pkg::COST_W-1:0]        cs_wr_data,
    input  wire  [ks01_pkg::COST_W-1:0]        cs_rd_data
);
    import ks01_pkg::*;

    localparam int EXTW = (AW > COST_W) ? AW : COST_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPD,
        ST_FLUSH,
        ST_TR_START,
        ST_TR_BEST,
        ST_TR_CHK,
        ST_TR_EVAL,
        ST_DONE
    } state_t;

    state_t                 state_reg,  state_next;
    logic [CNTW-1:0]        count_reg,  count_next;
    logic                   ovf_reg,    ovf_next;
    logic [AW-1:0]          w_reg,      w_next;
    logic                   upd_v_reg,  upd_v_next;
    logic [AW-1:0]          w_d_reg,    w_d_next;
    logic                   fits_d_reg, fits_d_next;
    logic                   first_reg,  first_next;
    logic [IN_PROFIT_W-1:0] profit_reg, profit_next;
    logic [COST_W-1:0]      cost_reg,   cost_next;
    logic                   last_reg,   last_next;
    logic [CNTW-1:0]        i_reg,      i_next;
    logic [AW-1:0]          j_reg,      j_next;
    logic [MASK_W-1:0]      mask_reg,   mask_next;
    logic [PROFIT_W-1:0]    best_reg,   best_next;
    logic                   m_valid_reg, m_valid_next;
    logic [PROFIT_W-1:0]    m_best_reg,  m_best_next;
    logic [MASK_W-1:0]      m_mask_reg,  m_mask_next;
    logic                   m_ovf_reg,   m_ovf_next;

    logic [EXTW-1:0]        lo_ext;
    logic                   fits;
    logic [EXTW-1:0]        cap_ext;
    logic [AW-1:0]          j0;
    logic [PROFIT_W-1:0]    old_best;
    logic [PROFIT_W-1:0]    base;
    logic [MAX_ITEMS-1:0]   old_take;
    logic [PROFIT_W:0]      cand;
    logic [PROFIT_W-1:0]    cand_sat;
    logic                   better;
    logic [MAX_ITEMS-1:0]   item_bit;
    logic [CNTW-1:0]        i_m1;

    // lower read address and fit test of the current budget
    assign lo_ext = EXTW'(w_reg) - EXTW'(cost_reg);
    assign fits   = (EXTW'(cost_reg) <= EXTW'(w_reg));

    // trace start budget, saturated to the row length
    assign cap_ext = EXTW'(capacity);
    assign j0 = (cap_ext > EXTW'(MAX_CAPACITY)) ? AW'(MAX_CAPACITY) : cap_ext[AW-1:0];

    // relax one budget: the first item of a problem sees an empty row
    assign old_best = first_reg ? '0 : pm_rd_data_a;
    assign base     = first_reg ? '0 : pm_rd_data_b;
    assign old_take = first_reg ? '0 : tk_rd_data;
    assign cand     = {1'b0, base} + (PROFIT_W+1)'(profit_reg);
    assign cand_sat = cand[PROFIT_W] ? PROFIT_MAX : cand[PROFIT_W-1:0];
    assign better   = fits_d_reg && (cand_sat > old_best);
    assign item_bit = MAX_ITEMS'(1) << count_reg;

    assign i_m1 = i_reg - CNTW'(1);

    // next state and memory commands
    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        ovf_next     = ovf_reg;
        w_next       = w_reg;
        upd_v_next   = 1'b0;
        w_d_next     = w_reg;
        fits_d_next  = fits;
        first_next   = first_reg;
        profit_next  = profit_reg;
        cost_next    = cost_reg;
        last_next    = last_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        mask_next    = mask_reg;
        best_next    = best_reg;
        m_valid_next = m_valid_reg && !out_ready;
        m_best_next  = m_best_reg;
        m_mask_next  = m_mask_reg;
        m_ovf_next   = m_ovf_reg;

        pm_ctl       = '0;
        pm_rd_addr_a = w_reg;
        pm_rd_addr_b = lo_ext[AW-1:0];
        pm_wr_addr   = w_d_reg;
        pm_wr_data   = better ? cand_sat : old_best;
        tk_ctl       = '0;
        tk_rd_addr   = w_reg;
        tk_wr_addr   = w_d_reg;
        tk_wr_data   = better ? (old_take | item_bit) : old_take;
        cs_ctl       = '0;
        cs_rd_addr   = i_m1[IDXW-1:0];
        cs_wr_addr   = count_reg[IDXW-1:0];
        cs_wr_data   = cost_reg;

        // write back the budget read in the previous cycle
        if (upd_v_reg) begin
            pm_ctl.wr_en = 1'b1;
            tk_ctl.wr_en = 1'b1;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    profit_next = in_profit;
                    cost_next   = in_cost;
                    last_next   = in_last;
                    if (count_reg == CNTW'(MAX_ITEMS)) begin
                        ovf_next = 1'b1;
                        if (in_last) begin
                            state_next = ST_TR_START;
                        end
                    end else begin
                        first_next = (count_reg == '0);
                        w_next     = AW'(MAX_CAPACITY);
                        state_next = ST_UPD;
                    end
                end
            end
            ST_UPD: begin
                pm_ctl.rd_en = 1'b1;
                tk_ctl.rd_en = 1'b1;
                upd_v_next   = 1'b1;
                w_next       = w_reg - AW'(1);
                if (w_reg == AW'(1)) begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                cs_ctl.wr_en = 1'b1;
                count_next   = count_reg + CNTW'(1);
                state_next   = last_reg ? ST_TR_START : ST_IDLE;
            end
            ST_TR_START: begin
                pm_ctl.rd_en = 1'b1;
                pm_rd_addr_a = j0;
                j_next       = j0;
                i_next       = count_reg;
                mask_next    = '0;
                state_next   = ST_TR_BEST;
            end
            ST_TR_BEST: begin
                best_next  = pm_rd_data_a;
                state_next = ST_TR_CHK;
            end
            ST_TR_CHK: begin
                if ((i_reg == '0) || (j_reg == '0)) begin
                    state_next = ST_DONE;
                end else begin
                    tk_ctl.rd_en = 1'b1;
                    tk_rd_addr   = j_reg;
                    cs_ctl.rd_en = 1'b1;
                    state_next   = ST_TR_EVAL;
                end
            end
            ST_TR_EVAL: begin
                if (tk_rd_data[i_m1[IDXW-1:0]]) begin
                    if (i_reg <= CNTW'(MASK_W)) begin
                        mask_next = mask_reg | (MASK_W'(1) << i_m1);
                    end
                    if (EXTW'(cs_rd_data) > EXTW'(j_reg)) begin
                        j_next = '0;
                    end else begin
                        j_next = j_reg - AW'(cs_rd_data);
                    end
                end
                i_next     = i_m1;
                state_next = ST_TR_CHK;
            end
            ST_DONE: begin
                if (!m_valid_reg || out_ready) begin
                    m_valid_next = 1'b1;
                    m_best_next  = best_reg;
                    m_mask_next  = mask_reg;
                    m_ovf_next   = ovf_reg;
                    count_next   = '0;
                    ovf_next     = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            upd_v_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            ovf_reg     <= ovf_next;
            upd_v_reg   <= upd_v_next;
            m_valid_reg <= m_valid_next;
        end
        w_reg      <= w_next;
        w_d_reg    <= w_d_next;
        fits_d_reg <= fits_d_next;
        first_reg  <= first_next;
        profit_reg <= profit_next;
        cost_reg   <= cost_next;
        last_reg   <= last_next;
        i_reg      <= i_next;
        j_reg      <= j_next;
        mask_reg   <= mask_next;
        best_reg   <= best_next;
        m_best_reg <= m_best_next;
        m_mask_reg <= m_mask_next;
        m_ovf_reg  <= m_ovf_next;
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = m_valid_reg;
    assign out_best  = m_best_reg;
    assign out_mask  = m_mask_reg;
    assign out_ovf   = m_ovf_reg;

endmodule

`default_nettype wire

// ===== design/ks01_checker.sv =====
// port-level checks on the knapsack selector result channel, bound to the top
// depends on ks01_pkg and knapsack_01_selector_macros.svh
`default_nettype none

`include "knapsack_01_selector_macros.svh"

module ks01_checker #(
    parameter int MAX_ITEMS = 32
) (
    input wire                            aclk,
    input wire                            aresetn,
    input wire                            m_tvalid,
    input wire                            m_tready,
    input wire [ks01_pkg::M_TDATA_W-1:0]  m_tdata,
    input wire                            m_tuser
);
    import ks01_pkg::*;

    logic [PROFIT_W-1:0] best_profit;
    logic [MASK_W-1:0]   chosen_mask;

    assign best_profit = m_tdata[PROFIT_W-1:0];
    assign chosen_mask = m_tdata[PROFIT_W +: MASK_W];

    // a stalled result stays offered and unchanged
    `KS01_ASSERT_NEXT(a_res_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
    `KS01_ASSERT_NEXT(a_res_stable, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

    // an item can only be chosen where it raised the profit
    `KS01_ASSERT_NOW(a_zero_profit, aclk, aresetn, m_tvalid && (best_profit == '0), chosen_mask == '0, "items chosen with zero best profit")

    // no item beyond the maximum count shows in the mask
    `KS01_ASSERT_NOW(a_mask_range, aclk, aresetn, m_tvalid, (chosen_mask >> MAX_ITEMS) == '0, "mask bit above item count")

endmodule

bind knapsack_01_selector ks01_checker #(
    .MAX_ITEMS (MAX_ITEMS)
) u_ks01_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

// ===== verif/tb_knapsack_01_selector.sv =====
// testbench for knapsack_01_selector: directed table, then random problems, results
// checked against the table's expected values or a behavioural knapsack predictor held here
// depends on ks01_pkg and the knapsack_01_selector rtl
`timescale 1ns / 1ps

module tb_knapsack_01_selector;

    import ks01_pkg::*;

    localparam int MAX_ITEMS     = 32;
    localparam int MAX_CAPACITY  = 255;
    localparam int RESET_CYCLES  = 8;
    // one full row sweep plus the longest trace back, with margin
    localparam int SETTLE_CYCLES = MAX_CAPACITY + 2 * MAX_ITEMS + 16;
    localparam int HOLD_CYCLES   = 20000;
    localparam int PHASE_ITEMS   = 88;
    localparam int N_PHASES      = 8;
    localparam int DRILL_N       = 20;

    // one expected solution of a problem
    typedef struct packed {
        logic [PROFIT_W-1:0] profit;
        logic [MASK_W-1:0]   mask;
        logic                dropped;
    } solution_t;

    // one row of the directed table
    typedef struct packed {
        logic                   set_cap;
        logic [CAP_W-1:0]       cap;
        logic [IN_PROFIT_W-1:0] profit;
        logic [COST_W-1:0]      cost;
        logic                   last;
        logic                   typed;
        solution_t              want;
    } drill_row_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CAP_W-1:0]     cfg_data  = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;   // item_profit[15:0], item_cost[23:16]
    logic                 s_tlast   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;          // best_profit[20:0], chosen_mask[52:21], pad
    logic                 m_tuser;          // too_many_items[0]

    // predictor state
    logic [PROFIT_W-1:0]  row_best [0:MAX_CAPACITY];
    logic [MAX_ITEMS-1:0] row_take [0:MAX_CAPACITY];
    logic [COST_W-1:0]    held_cost [0:MAX_ITEMS-1];
    int unsigned          held_n;
    logic                 dropped_any;
    logic [CAP_W-1:0]     cap_reg = '0;

    solution_t   solutions_due [$];
    int unsigned mismatches   = 0;
    int unsigned results_seen = 0;
    int unsigned hold_at      = 32'hFFFF_FFFF;
    bit          calm         = 1'b0;

    drill_row_t drill_tab [DRILL_N] = '{
        // reset capacity of zero: nothing fits
        '{1'b0, 8'd0,   16'hFFFF, 8'd0,   1'b1, 1'b1, '{21'd0, 32'd0, 1'b0}},
        // full budget, largest profits, both items chosen
        '{1'b1, 8'd255, 16'hFFFF, 8'd255, 1'b0, 1'b0, '{21'd0, 32'd0, 1'b0}},
        '{1'b0, 8'd0,   16'hFFFF, 8'd0,   1'b1, 1'b1, '{21'd131070, 32'd3, 1'b0}},
        // tie: the second item does not strictly improve
        '{1'b1, 8'd5,   16'd10,   8'd5,   1'b0, 1'b0, '{21'd0, 32'd0, 1'b0}},
        '{1'b0, 8'd0,   16'd10,   8'd5,   1'b1, 1'b1, '{21'd10, 32'd1, 1'b0}},
        // zero profit never chosen
        '{1'b0, 8'd0,   16'd0,    8'd0,   1'b1, 1'b1, '{21'd0, 32'd0, 1'b0}},
        // cost above the budget
        '{1'b0, 8'd0,   16'd100,  8'd6,   1'b1, 1'b1, '{21'd0, 32'd0, 1'b0}},
        '{1'b0, 8'd0,   16'd7,    8'd0,   1'b0, 1'b0, '{21'd0, 32'd0, 1'b0}},
        '{1'b0, 8'd0,   16'd3,    8'd2,   1'b0, 1'b0, '{21'd0, 32'd0, 1'b0}},
        '{1'b0, 8'd0,   16'd4,    8'd3,   1'b0, 1'b0, '{21'd0, 32'd0, 1'b0}},
        '{1'b0, 8'd0,   16'd9,    8'd5,   1'b1, 1'b0, '{21'd0, 32'd0, 1'b0}},
        // budget of one
        '{1'b1, 8'd1,   16'd5,    8'd1,   1'b0, 1'b0, '{21'd0, 32'd0, 1'b0}},
        '{1'b0, 8'd0,   16'd6,    8'd1,   1'b1, 1'b1, '{21'd6, 32'd2, 1'b0}},
        // budget one below the top, largest cost never fits
        '{1'b1, 8'd254, 16'hFFFF, 8'd255, 1'b0, 1'b0, '{21'd0, 32'd0, 1'b0}},
        '{1'b0, 8'd0,   16'd1,    8'd254, 1'b1, 1'b1, '{21'd1, 32'd2, 1'b0}},
        // mixed problem at the full budget
        '{1'b1, 8'd255, 16'd1000, 8'd100, 1'b0, 1'b0, '{21'd0, 32'd0, 1'b0}},
        '{1'b0, 8'd0,   16'd2000, 8'd150, 1'b0, 1'b0, '{21'd0, 32'd0, 1'b0}},
        '{1'b0, 8'd0,   16'd1500, 8'd155, 1'b0, 1'b0, '{21'd0, 32'd0, 1'b0}},
        '{1'b0, 8'd0,   16'd2500, 8'd200, 1'b0, 1'b0, '{21'd0, 32'd0, 1'b0}},
        '{1'b0, 8'd0,   16'd800,  8'd55,  1'b1, 1'b0, '{21'd0, 32'd0, 1'b0}}
    };

    knapsack_01_selector #(
        .MAX_ITEMS    (MAX_ITEMS),
        .MAX_CAPACITY (MAX_CAPACITY)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // run limit, far beyond the slowest correct run
    initial begin
        #(64'd25_000_000);
        $display("knapsack_01_selector: mismatch");
        $finish;
    end

    // idle length: mostly short, a few long
    function automatic int unsigned gap_len();
        if ($urandom_range(0, 9) != 0)
            return $urandom_range(1, 4);
        return $urandom_range(20, 300);
    endfunction

    // empty the row and the item store for the next problem
    function automatic void wipe_problem();
        for (int w = 0; w <= MAX_CAPACITY; w++) begin
            row_best[w] = '0;
            row_take[w] = '0;
        end
        for (int k = 0; k < MAX_ITEMS; k++)
            held_cost[k] = '0;
        held_n      = 0;
        dropped_any = 1'b0;
    endfunction

    // fold one item into the row; on the last item trace back the choice
    function automatic bit absorb_item(input logic [IN_PROFIT_W-1:0] profit,
                                       input logic [COST_W-1:0] cost,
                                       input logic last,
                                       output solution_t sol);
        int unsigned cand;
        int unsigned i;
        int unsigned j;
        sol = '0;
        if (held_n < MAX_ITEMS) begin
            // sweep from the top budget down so each item counts once
            for (int w = MAX_CAPACITY; w >= 1; w--) begin
                if (int'(cost) <= w) begin
                    cand = profit + row_best[w - cost];
                    if (cand > PROFIT_MAX)
                        cand = PROFIT_MAX;
                    if (cand > row_best[w]) begin
                        row_best[w]         = cand[PROFIT_W-1:0];
                        row_take[w][held_n] = 1'b1;
                    end
                end
            end
            held_cost[held_n] = cost;
            held_n++;
        end else begin
            dropped_any = 1'b1;
        end
        if (!last)
            return 1'b0;
        j = (cap_reg > MAX_CAPACITY) ? MAX_CAPACITY : cap_reg;
        i = held_n;
        sol.profit = row_best[j];
        // walk back through the take bits while items and budget remain
        while (i > 0 && j > 0) begin
            if (row_take[j][i-1]) begin
                if (i <= MASK_W)
                    sol.mask[i-1] = 1'b1;
                if (held_cost[i-1] > j)
                    j = 0;
                else
                    j = j - held_cost[i-1];
            end
            i--;
        end
        sol.dropped = dropped_any;
        wipe_problem();
        return 1'b1;
    endfunction

    // hand one item to the block and record what it should produce
    task automatic offer_item(input logic [IN_PROFIT_W-1:0] profit,
                              input logic [COST_W-1:0] cost,
                              input logic last,
                              input logic typed,
                              input solution_t want);
        int unsigned gap;
        solution_t   sol;
        gap = (!calm && $urandom_range(0, 9) < 4) ? gap_len() : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {cost, profit};
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        if (absorb_item(profit, cost, last, sol))
            solutions_due.insert(solutions_due.size(), typed ? want : sol);
    endtask

    // let the block drain, then write a new capacity
    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (solutions_due.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= cap;
        do @(posedge aclk); while (!cfg_ready);
        cap_reg = cap;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic note_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("%0t ns: %s got %0h, expected %0h", $time, what, got, want);
        mismatches++;
    endtask

    // result side: random stalls plus one long hold-off
    initial begin : result_sink
        int unsigned stall_left;
        bit          hold_done;
        stall_left = 0;
        hold_done  = 1'b0;
        forever begin
            @(negedge aclk);
            if (!hold_done && results_seen >= hold_at) begin
                hold_done  = 1'b1;
                stall_left = HOLD_CYCLES;
            end else if (stall_left == 0 && !calm && $urandom_range(0, 49) == 0) begin
                stall_left = gap_len();
            end
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // compare each result transfer with the oldest expected solution
    always @(posedge aclk) begin : result_check
        solution_t due;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (solutions_due.size() == 0) begin
                note_mismatch("result with none expected, best_profit",
                              32'(m_tdata[PROFIT_W-1:0]), 32'd0);
            end else begin
                due = solutions_due.pop_front();
                if (m_tdata[PROFIT_W-1:0] !== due.profit)
                    note_mismatch("best_profit", 32'(m_tdata[PROFIT_W-1:0]),
                                  32'(due.profit));
                if (m_tdata[PROFIT_W +: MASK_W] !== due.mask)
                    note_mismatch("chosen_mask", m_tdata[PROFIT_W +: MASK_W], due.mask);
                if (m_tuser !== due.dropped)
                    note_mismatch("too_many_items", 32'(m_tuser), 32'(due.dropped));
            end
        end
    end

    // stimulus: reset, directed table, then random problems per capacity
    initial begin : stimulus
        logic [CAP_W-1:0]       cap;
        logic [IN_PROFIT_W-1:0] profit;
        logic [COST_W-1:0]      cost;
        int unsigned            n;
        int unsigned            span;
        int unsigned            r;
        int unsigned            phase_items;
        wipe_problem();
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (drill_tab[row]) begin
            if (drill_tab[row].set_cap)
                write_capacity(drill_tab[row].cap);
            offer_item(drill_tab[row].profit, drill_tab[row].cost, drill_tab[row].last,
                       drill_tab[row].typed, drill_tab[row].want);
        end

        // long hold-off on the result side early in the random part
        hold_at = results_seen + 3;

        for (int p = 0; p < N_PHASES; p++) begin
            case (p)
                0, 7:    cap = 8'd255;
                1:       cap = 8'd0;
                2:       cap = 8'd1;
                4:       cap = 8'd254;
                6:       cap = 8'($urandom_range(2, 20));
                default: cap = 8'($urandom_range(2, 253));
            endcase
            write_capacity(cap);
            calm        = (p != 0) && ($urandom_range(0, 3) == 0);
            phase_items = 0;
            span        = (cap < 3) ? cap : cap / 3;
            while (phase_items < PHASE_ITEMS) begin
                // mostly small problems, some near and beyond the item limit
                r = $urandom_range(0, 9);
                if (r < 7)
                    n = $urandom_range(1, 8);
                else if (r < 9)
                    n = $urandom_range(9, MAX_ITEMS - 1);
                else
                    n = MAX_ITEMS + $urandom_range(0, 2) * $urandom_range(0, 4);
                for (int k = 1; k <= n; k++) begin
                    r = $urandom_range(0, 9);
                    profit = (r == 0) ? 16'h0 : (r == 1) ? 16'hFFFF : 16'($urandom);
                    r = $urandom_range(0, 9);
                    if (r == 0)
                        cost = 8'd0;
                    else if (r == 1)
                        cost = 8'd255;
                    else if (r < 7)
                        cost = 8'($urandom_range(0, span));
                    else
                        cost = 8'($urandom_range(0, 255));
                    offer_item(profit, cost, k == n, 1'b0, '0);
                    phase_items++;
                end
            end
        end

        // drain and finish
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (solutions_due.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("knapsack_01_selector: match");
        else
            $display("knapsack_01_selector: mismatch");
        $finish;
    end

endmodule

// ===== knapsack_01_selector.f =====
+incdir+design
design/ks01_pkg.sv
design/ks01_profit_mem.sv
design/ks01_take_mem.sv
design/ks01_seq.sv
design/knapsack_01_selector.sv
design/ks01_checker.sv
verif/tb_knapsack_01_selector.sv
